// File: sv/a51_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a51_pkg
// Shared types and constants of the A5/1 keystream generator.
// ----------------------------------------------------------------------------
package a51_pkg;

  localparam int KEY_W   = 64;
  localparam int FRAME_W = 22;
  localparam int R1_W    = 19;
  localparam int R2_W    = 22;
  localparam int R3_W    = 23;

  localparam logic [R1_W-1:0] R1_TAPS = 19'h72000;
  localparam logic [R2_W-1:0] R2_TAPS = 22'h300000;
  localparam logic [R3_W-1:0] R3_TAPS = 23'h700080;

  localparam int R1_MID = 8;
  localparam int R2_MID = 10;
  localparam int R3_MID = 10;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_ALL   = 2'd2,
    OP_MAJ   = 2'd3
  } lfsr_op_t;

  typedef struct packed {
    lfsr_op_t op;
    logic     inbit;
  } lfsr_ctrl_t;

endpackage

// File: sv/a51_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a51 channel interfaces
// Valid/ready channels for frame input, keystream output and key write.
// ----------------------------------------------------------------------------
interface a51_in_if;
  logic                         valid;
  logic                         ready;
  logic [a51_pkg::FRAME_W-1:0]  frame_number;
  modport source (output valid, output frame_number, input ready);
  modport sink   (input valid, input frame_number, output ready);
endinterface

interface a51_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] keystream_byte;
  logic       direction;
  logic [3:0] byte_index;
  logic       last;
  modport source (output valid, output keystream_byte, output direction,
                  output byte_index, output last, input ready);
  modport sink   (input valid, input keystream_byte, input direction,
                  input byte_index, input last, output ready);
endinterface

interface a51_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [a51_pkg::KEY_W-1:0]   session_key;
  modport source (output valid, output session_key, input ready);
  modport sink   (input valid, input session_key, output ready);
endinterface

// File: sv/a51_lfsr_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a51_lfsr_unit
// The three A5/1 shift registers with clear, clock-all and majority step.
// ----------------------------------------------------------------------------
module a51_lfsr_unit (
  input  logic                clk,
  input  a51_pkg::lfsr_ctrl_t ctrl,
  output logic                step_bit
);

  logic [a51_pkg::R1_W-1:0] r1_r, r1_nxt, r1_sh;
  logic [a51_pkg::R2_W-1:0] r2_r, r2_nxt, r2_sh;
  logic [a51_pkg::R3_W-1:0] r3_r, r3_nxt, r3_sh;
  logic                     m1, m2, m3, maj;

  always_comb begin
    r1_sh = {r1_r[a51_pkg::R1_W-2:0], ^(r1_r & a51_pkg::R1_TAPS)};
    r2_sh = {r2_r[a51_pkg::R2_W-2:0], ^(r2_r & a51_pkg::R2_TAPS)};
    r3_sh = {r3_r[a51_pkg::R3_W-2:0], ^(r3_r & a51_pkg::R3_TAPS)};
    m1  = r1_r[a51_pkg::R1_MID];
    m2  = r2_r[a51_pkg::R2_MID];
    m3  = r3_r[a51_pkg::R3_MID];
    maj = (m1 & m2) | (m1 & m3) | (m2 & m3);
    r1_nxt = r1_r;
    r2_nxt = r2_r;
    r3_nxt = r3_r;
    case (ctrl.op)
      a51_pkg::OP_CLEAR: begin
        r1_nxt = '0;
        r2_nxt = '0;
        r3_nxt = '0;
      end
      a51_pkg::OP_ALL: begin
        r1_nxt = r1_sh ^ {{(a51_pkg::R1_W-1){1'b0}}, ctrl.inbit};
        r2_nxt = r2_sh ^ {{(a51_pkg::R2_W-1){1'b0}}, ctrl.inbit};
        r3_nxt = r3_sh ^ {{(a51_pkg::R3_W-1){1'b0}}, ctrl.inbit};
      end
      a51_pkg::OP_MAJ: begin
        if (m1 == maj) r1_nxt = r1_sh;
        if (m2 == maj) r2_nxt = r2_sh;
        if (m3 == maj) r3_nxt = r3_sh;
      end
      default: begin
        r1_nxt = r1_r;
      end
    endcase
    // keystream bit of the stepped state
    step_bit = r1_nxt[a51_pkg::R1_W-1] ^ r2_nxt[a51_pkg::R2_W-1] ^
               r3_nxt[a51_pkg::R3_W-1];
  end

  always_ff @(posedge clk) begin
    r1_r <= r1_nxt;
    r2_r <= r2_nxt;
    r3_r <= r3_nxt;
  end

endmodule

// File: sv/a5_1_keystream_generator_top.sv
`timescale 1ns / 1ps
// A frame transaction clears the registers, then key and frame are loaded, the
//   state is mixed by MIX_STEPS majority steps and keystream bytes are registered;
//   one LFSR step per cycle through the shared register unit, but for stalls while
//   a finished byte waits on out_ch.ready. A new frame is taken only in idle.
// Reset: synchronous active-low rst_n returns the sequencer to idle, drops the
//   output valid and clears the session key to zero.
// ----------------------------------------------------------------------------
// a5_1_keystream_generator_top
// A5/1 key setup and keystream generation, emitted as bytes per direction.
// ----------------------------------------------------------------------------
module a5_1_keystream_generator_top #(
  parameter int MIX_STEPS          = 100,
  parameter int BITS_PER_DIRECTION = 114
) (
  input  logic      clk,
  input  logic      rst_n,
  a51_in_if.sink    in_ch,
  a51_out_if.source out_ch,
  a51_cfg_if.sink   cfg_ch
);

  localparam int LOAD_STEPS = a51_pkg::KEY_W + a51_pkg::FRAME_W;
  localparam int MIX_CW     = $clog2(MIX_STEPS);
  localparam int CNT_W      = (MIX_CW > 7) ? MIX_CW : 7;
  localparam int BIT_CW     = $clog2(BITS_PER_DIRECTION);
  localparam int STEP_W     = (BIT_CW > 7) ? BIT_CW : 7;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_MIX  = 4'b0100,
    ST_GEN  = 4'b1000
  } seq_state_t;

  seq_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic                     dir_r, dir_nxt;
  logic [7:0]               acc_r, acc_nxt, acc_new;
  logic [LOAD_STEPS-1:0]    sh_r, sh_nxt;
  logic [a51_pkg::KEY_W-1:0] key_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_byte_r;
  logic                     out_dir_r;
  logic [3:0]               out_idx_r;
  logic                     out_last_r;

  a51_pkg::lfsr_ctrl_t      ctrl;
  logic                     step_bit;
  logic                     can_emit, bit_last, byte_end, emit;
  logic [2:0]               pos;

  a51_lfsr_unit u_lfsr (
    .clk      (clk),
    .ctrl     (ctrl),
    .step_bit (step_bit)
  );

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.keystream_byte = out_byte_r;
  assign out_ch.direction      = out_dir_r;
  assign out_ch.byte_index     = out_idx_r;
  assign out_ch.last           = out_last_r;

  always_comb begin
    can_emit  = !out_valid_r || out_ch.ready;
    pos       = step_r[2:0];
    bit_last  = (step_r == STEP_W'(BITS_PER_DIRECTION - 1));
    byte_end  = (pos == 3'd7) || bit_last;
    acc_new   = acc_r | ({7'd0, step_bit} << (3'd7 - pos));
    emit      = 1'b0;
    ctrl.op    = a51_pkg::OP_HOLD;
    ctrl.inbit = 1'b0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    dir_nxt   = dir_r;
    acc_nxt   = acc_r;
    sh_nxt    = sh_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          ctrl.op   = a51_pkg::OP_CLEAR;
          sh_nxt    = {in_ch.frame_number, key_r};
          cnt_nxt   = CNT_W'(LOAD_STEPS - 1);
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctrl.op    = a51_pkg::OP_ALL;
        ctrl.inbit = sh_r[0];
        sh_nxt     = sh_r >> 1;
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(MIX_STEPS - 1);
          state_nxt = ST_MIX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_MIX: begin
        ctrl.op = a51_pkg::OP_MAJ;
        if (cnt_r == '0) begin
          step_nxt  = '0;
          dir_nxt   = 1'b0;
          acc_nxt   = '0;
          state_nxt = ST_GEN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_GEN: begin
        if (!byte_end || can_emit) begin
          ctrl.op = a51_pkg::OP_MAJ;
          if (byte_end) begin
            emit    = 1'b1;
            acc_nxt = '0;
          end else begin
            acc_nxt = acc_new;
          end
          if (bit_last) begin
            step_nxt = '0;
            dir_nxt  = 1'b1;
            if (dir_r) state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
      key_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) key_r <= cfg_ch.session_key;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    if (emit) begin
      out_byte_r <= acc_new;
      out_dir_r  <= dir_r;
      out_idx_r  <= step_r[6:3];
      out_last_r <= dir_r && bit_last;
    end
  end

endmodule

// File: tb/a5_1_keystream_generator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a5_1_keystream_generator_top_tb
// Self-checking bench for the A5/1 keystream generator. Frame transactions
// are driven with random gaps and the byte stream is accepted under random
// back-pressure. A scoreboard reruns key setup and keystream generation for
// each accepted frame and compares every byte, field by field, in order.
// The session key is changed between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module a5_1_keystream_generator_top_tb;

  localparam int MIX_STEPS          = 100;
  localparam int BITS_PER_DIRECTION = 114;
  localparam int CYCLE_LIMIT        = 5_000_000;
  localparam int RANDOM_PHASES      = 8;
  localparam int FRAMES_PER_PHASE   = 58;
  localparam int TAIL_CYCLES        = 450;

  typedef struct packed {
    logic [7:0] ks;
    logic       dir;
    logic [3:0] idx;
    logic       fin;
  } ks_byte_t;

  class keystream_scoreboard;
    logic [a51_pkg::KEY_W-1:0] key;
    logic [a51_pkg::R1_W-1:0]  r1;
    logic [a51_pkg::R2_W-1:0]  r2;
    logic [a51_pkg::R3_W-1:0]  r3;
    ks_byte_t                  pending[$];
    int                        errors;
    int                        frames;
    int                        bytes_ok;
    int                        key_writes;

    function new();
      key = '0;
      errors = 0;
      frames = 0;
      bytes_ok = 0;
      key_writes = 0;
    endfunction

    function void set_key(logic [a51_pkg::KEY_W-1:0] k);
      key = k;
      key_writes++;
    endfunction

    function void clock_all(logic inbit);
      r1 = {r1[a51_pkg::R1_W-2:0], ^(r1 & a51_pkg::R1_TAPS) ^ inbit};
      r2 = {r2[a51_pkg::R2_W-2:0], ^(r2 & a51_pkg::R2_TAPS) ^ inbit};
      r3 = {r3[a51_pkg::R3_W-2:0], ^(r3 & a51_pkg::R3_TAPS) ^ inbit};
    endfunction

    function void clock_majority();
      logic ma, mb, mc, maj;
      ma  = r1[a51_pkg::R1_MID];
      mb  = r2[a51_pkg::R2_MID];
      mc  = r3[a51_pkg::R3_MID];
      maj = (ma & mb) | (ma & mc) | (mb & mc);
      if (ma == maj) r1 = {r1[a51_pkg::R1_W-2:0], ^(r1 & a51_pkg::R1_TAPS)};
      if (mb == maj) r2 = {r2[a51_pkg::R2_W-2:0], ^(r2 & a51_pkg::R2_TAPS)};
      if (mc == maj) r3 = {r3[a51_pkg::R3_W-2:0], ^(r3 & a51_pkg::R3_TAPS)};
    endfunction

    function void note_frame(logic [a51_pkg::FRAME_W-1:0] frame);
      ks_byte_t   e;
      logic [7:0] acc;
      int         pos;
      frames++;
      r1 = '0;
      r2 = '0;
      r3 = '0;
      for (int i = 0; i < a51_pkg::KEY_W; i++) clock_all(key[i]);
      for (int i = 0; i < a51_pkg::FRAME_W; i++) clock_all(frame[i]);
      for (int i = 0; i < MIX_STEPS; i++) clock_majority();
      for (int d = 0; d < 2; d++) begin
        acc = '0;
        for (int s = 0; s < BITS_PER_DIRECTION; s++) begin
          pos = s % 8;
          clock_majority();
          acc[7-pos] = r1[a51_pkg::R1_W-1] ^ r2[a51_pkg::R2_W-1] ^ r3[a51_pkg::R3_W-1];
          if (pos == 7 || s + 1 == BITS_PER_DIRECTION) begin
            e.ks  = acc;
            e.dir = d[0];
            e.idx = 4'((s >> 3) & 15);
            e.fin = (d == 1) && (s + 1 == BITS_PER_DIRECTION);
            pending.push_back(e);
            acc = '0;
          end
        end
      end
    endfunction

    function void check_byte(ks_byte_t got);
      ks_byte_t exp_b;
      bit       bad;
      if (pending.size() == 0) begin
        $display("%0t unexpected keystream transaction: byte %h dir %0d idx %0d last %0d",
                 $time, got.ks, got.dir, got.idx, got.fin);
        errors++;
        return;
      end
      exp_b = pending.pop_front();
      bad = 0;
      if (got.ks !== exp_b.ks) begin
        $display("%0t keystream_byte mismatch: expected %h actual %h", $time, exp_b.ks, got.ks);
        bad = 1;
      end
      if (got.dir !== exp_b.dir) begin
        $display("%0t direction mismatch: expected %0d actual %0d", $time, exp_b.dir, got.dir);
        bad = 1;
      end
      if (got.idx !== exp_b.idx) begin
        $display("%0t byte_index mismatch: expected %0d actual %0d", $time, exp_b.idx, got.idx);
        bad = 1;
      end
      if (got.fin !== exp_b.fin) begin
        $display("%0t last mismatch: expected %0d actual %0d", $time, exp_b.fin, got.fin);
        bad = 1;
      end
      if (bad) errors++;
      else bytes_ok++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  bit   out_free;
  bit   in_free;
  int   out_hold;

  a51_in_if  in_if ();
  a51_out_if out_if ();
  a51_cfg_if cfg_if ();

  keystream_scoreboard sb;

  a5_1_keystream_generator_top #(
    .MIX_STEPS          (MIX_STEPS),
    .BITS_PER_DIRECTION (BITS_PER_DIRECTION)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycles, sb.pending.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_key(cfg_if.session_key);
      if (in_if.valid && in_if.ready) sb.note_frame(in_if.frame_number);
      if (out_if.valid && out_if.ready)
        sb.check_byte('{out_if.keystream_byte, out_if.direction,
                        out_if.byte_index, out_if.last});
    end
  end

  // back-pressure on the keystream side
  initial begin
    out_hold = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (out_hold > 0) begin
        out_if.ready <= 1'b0;
        out_hold--;
      end else begin
        out_if.ready <= 1'b1;
        if (!out_free && $urandom_range(0, 9) == 0) out_hold = pick_gap();
      end
    end
  end

  task automatic send_frame(logic [a51_pkg::FRAME_W-1:0] frame);
    int gap;
    gap = in_free ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.frame_number <= frame;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_key(logic [a51_pkg::KEY_W-1:0] k);
    drain();
    @(negedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.session_key <= k;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [a51_pkg::FRAME_W-1:0] rand_frame();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return a51_pkg::FRAME_W'(1) << $urandom_range(0, a51_pkg::FRAME_W - 1);
    return a51_pkg::FRAME_W'($urandom);
  endfunction

  initial begin
    logic [a51_pkg::KEY_W-1:0] k;
    sb                 = new();
    cycles             = 0;
    out_free           = 0;
    in_free            = 0;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.frame_number = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.session_key = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // key left at its reset value
    send_frame('0);
    send_frame('1);
    send_frame(22'h000001);

    write_key('1);
    send_frame('0);
    send_frame('1);
    send_frame(22'h155555);
    send_frame(22'h2AAAAA);
    send_frame(22'h200000);

    write_key(64'h8000_0000_0000_0001);
    in_free  = 1;
    out_free = 1;
    send_frame(22'h000001);
    send_frame(22'h100000);
    send_frame(22'h0F0F0F);
    in_free  = 0;
    out_free = 0;

    write_key(64'h5555_5555_5555_5555);
    send_frame(22'h2AAAAA);
    send_frame(22'h3FFFFE);

    write_key(64'hAAAA_AAAA_AAAA_AAAA);
    send_frame(22'h155555);
    send_frame(22'h000000);

    write_key('0);
    send_frame(22'h3FFFFF);
    send_frame(22'h12345);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        3:       k = '1;
        6:       k = '0;
        default: k = {$urandom, $urandom};
      endcase
      write_key(k);
      out_free = (p % 4 == 1);
      in_free  = (p % 4 == 2);
      for (int n = 0; n < FRAMES_PER_PHASE; n++) send_frame(rand_frame());
    end
    out_free = 0;
    in_free  = 0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d frames under %0d key writes, %0d keystream bytes matched",
             sb.frames, sb.key_writes, sb.bytes_ok);
    $display("gapped and back-to-back frames, output stalls short and long, key extremes");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
